// ----- rtl/moi_pkg.sv -----
// Shared types and constants of the mecanum odometry integrator.
`default_nettype none

package moi_pkg;

   // CORDIC iterations and position accumulator width
   localparam int CORDIC_STEPS = 24;
   localparam int POS_W        = 48;

   // sequencer counter: indexes the 32-entry angle table
   localparam int CNT_W = 5;

   // shared multiplier: 35-bit signed by 18-bit signed
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // datapath widths
   localparam int SUM_W  = 35;             // sum of four wheel distances
   localparam int FWD_W  = SUM_W - 2;      // forward / sideways move
   localparam int TURN_W = 60;             // wheel difference times gain
   localparam int CS_W   = 34;             // CORDIC x, y and cos / sin, Q.30
   localparam int ROT_W  = 68;             // rotation sums, Q.30 scaled
   localparam int DX_W   = ROT_W - 30;     // world-frame step
   localparam int SAT_W  = ((POS_W > DX_W) ? POS_W : DX_W) + 1;
   localparam int GAIN_W = 24;
   localparam int GAIN_HALF_W = GAIN_W / 2;
   localparam int CS_LO_W = 17;            // low unsigned slice of cos / sin

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
   localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

   // atan(2^-i) in binary-angle units, rounded to nearest
   localparam logic [31:0] ATAN_TABLE [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004755,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // register file
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_RL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_RR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN    = 3'd4;

   localparam logic [15:0]       COEF_FL_RESET = 16'd2652;
   localparam logic [15:0]       COEF_FR_RESET = 16'd2633;
   localparam logic [15:0]       COEF_RL_RESET = 16'd2635;
   localparam logic [15:0]       COEF_RR_RESET = 16'd2644;
   localparam logic [GAIN_W-1:0] GAIN_RESET    = 24'd5602994;

   // input beat: encoder pulse increments
   typedef struct packed {
      logic signed [15:0] pulses_front_left;
      logic signed [15:0] pulses_front_right;
      logic signed [15:0] pulses_rear_left;
      logic signed [15:0] pulses_rear_right;
   } req_payload_type;

   // result beat: pose after the update
   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic [31:0]        heading;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ----- rtl/mecanum_odometry_integrator.sv -----
// Mecanum wheel odometry integrator: top level, sequencer and shared datapath.
//
// Usage
//   req channel: one beat carries four signed pulse increments, one per wheel.
//   rsp channel: one beat per request, world x / y (cm, Q.16, saturating) and
//   the wrapping binary-angle heading after the update.
//   csr port: APB-style, wheel coefficients at 0x00..0x0C, heading gain at 0x10.
//   Write registers only while the block is idle.
// Sequence
//   After a request is accepted the block steps through the wheel and turn
//   products, a setup step, one CORDIC iteration per cycle, a quadrant step,
//   the rotation products and an update step, and then raises rsp_valid. All
//   products go through one 35x18 signed multiplier. req_ready is high only
//   between items, so a new request is taken only once the last one's update
//   is done.
// Reset
//   Positions and heading clear to zero, registers take their default values.
// Stalls
//   The result sits in an output register; the next request is accepted while
//   it waits. A finished update waits in its last cycle until that register
//   has been taken.
`default_nettype none

module mecanum_odometry_integrator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  moi_pkg::req_payload_type         req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output moi_pkg::rsp_payload_type         rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [moi_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_IN,
      ST_SETUP,
      ST_CORDIC,
      ST_QUAD,
      ST_MUL_ROT,
      ST_DONE
   } state_type;

   // what the multiplier works on this cycle
   typedef enum logic [3:0] {
      P_NONE,
      P_LF,
      P_RF,
      P_LR,
      P_RR,
      P_TURN_LO,
      P_TURN_HI,
      P_FC_LO,
      P_FC_HI,
      P_SS_LO,
      P_SS_HI,
      P_FS_LO,
      P_FS_HI,
      P_SC_LO,
      P_SC_HI
   } prod_type;

   localparam logic signed [moi_pkg::SAT_W-1:0] POS_MAX =
      {{(moi_pkg::SAT_W - moi_pkg::POS_W + 1){1'b0}}, {(moi_pkg::POS_W - 1){1'b1}}};
   localparam logic signed [moi_pkg::SAT_W-1:0] POS_MIN = ~POS_MAX;

   // control
   state_type                        state_ff, state_in;
   logic [moi_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   prod_type                         tag_ff, tag_in, issue_tag;
   logic                             rsp_valid_ff, rsp_valid_in;

   // registers and pose
   logic [15:0]                      coef_fl_ff, coef_fl_in;
   logic [15:0]                      coef_fr_ff, coef_fr_in;
   logic [15:0]                      coef_rl_ff, coef_rl_in;
   logic [15:0]                      coef_rr_ff, coef_rr_in;
   logic [moi_pkg::GAIN_W-1:0]       gain_ff, gain_in;
   logic signed [moi_pkg::POS_W-1:0] world_x_ff, world_x_in;
   logic signed [moi_pkg::POS_W-1:0] world_y_ff, world_y_in;
   logic [31:0]                      heading_ff, heading_in;

   // datapath
   moi_pkg::req_payload_type         pulses_ff, pulses_in;
   moi_pkg::rsp_payload_type         rsp_data_ff, rsp_data_in;
   logic signed [moi_pkg::MUL_P_W-1:0] prod_ff, prod_in;
   logic signed [moi_pkg::SUM_W-1:0] fwd_sum_ff, fwd_sum_in;
   logic signed [moi_pkg::SUM_W-1:0] side_sum_ff, side_sum_in;
   logic signed [moi_pkg::SUM_W-1:0] turn_sum_ff, turn_sum_in;
   logic signed [moi_pkg::TURN_W-1:0] turn_acc_ff, turn_acc_in;
   logic signed [moi_pkg::ROT_W-1:0] rot_x_ff, rot_x_in;
   logic signed [moi_pkg::ROT_W-1:0] rot_y_ff, rot_y_in;
   logic signed [moi_pkg::CS_W-1:0]  x_ff, x_in;
   logic signed [moi_pkg::CS_W-1:0]  y_ff, y_in;
   logic signed [31:0]               z_ff, z_in;
   logic [1:0]                       quad_ff, quad_in;
   logic signed [moi_pkg::CS_W-1:0]  cos_ff, cos_in;
   logic signed [moi_pkg::CS_W-1:0]  sin_ff, sin_in;

   // combinational helpers
   logic signed [moi_pkg::MUL_A_W-1:0] mul_a;
   logic signed [moi_pkg::MUL_B_W-1:0] mul_b;
   logic signed [moi_pkg::MUL_P_W-1:0] mul_p;
   logic signed [moi_pkg::FWD_W-1:0]   fwd;
   logic signed [moi_pkg::FWD_W-1:0]   side;
   logic signed [moi_pkg::SUM_W-1:0]   wheel_term;
   logic signed [moi_pkg::TURN_W-1:0]  turn_term;
   logic signed [moi_pkg::ROT_W-1:0]   rot_term;
   logic signed [moi_pkg::CS_W-1:0]    x_sh;
   logic signed [moi_pkg::CS_W-1:0]    y_sh;
   logic signed [31:0]                 atan_val;
   logic [31:0]                        mid;
   logic [31:0]                        mid_shift;
   logic signed [moi_pkg::POS_W-1:0]   new_x;
   logic signed [moi_pkg::POS_W-1:0]   new_y;
   logic [31:0]                        new_heading;
   logic                               csr_write;
   logic [moi_pkg::CSR_IDX_W-1:0]      csr_idx;

   // clamp the position update to the accumulator range
   function automatic logic signed [moi_pkg::POS_W-1:0] sat_add(
      input logic signed [moi_pkg::POS_W-1:0] acc,
      input logic signed [moi_pkg::DX_W-1:0]  d
   );
      logic signed [moi_pkg::SAT_W-1:0] s;
      s = moi_pkg::SAT_W'(acc) + moi_pkg::SAT_W'(d);
      if (s > POS_MAX) begin
         s = POS_MAX;
      end else if (s < POS_MIN) begin
         s = POS_MIN;
      end
      return s[moi_pkg::POS_W-1:0];
   endfunction

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[moi_pkg::CSR_ADDR_W-1:2];

   assign fwd  = fwd_sum_ff[moi_pkg::SUM_W-1:2];
   assign side = side_sum_ff[moi_pkg::SUM_W-1:2];

   // register readback
   always_comb begin
      unique case (csr_idx)
         moi_pkg::CSR_COEF_FL: csr_prdata = {16'd0, coef_fl_ff};
         moi_pkg::CSR_COEF_FR: csr_prdata = {16'd0, coef_fr_ff};
         moi_pkg::CSR_COEF_RL: csr_prdata = {16'd0, coef_rl_ff};
         moi_pkg::CSR_COEF_RR: csr_prdata = {16'd0, coef_rr_ff};
         moi_pkg::CSR_GAIN:    csr_prdata = {8'd0, gain_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // product schedule
   always_comb begin
      issue_tag = P_NONE;
      unique case (state_ff)
         ST_MUL_IN: begin
            unique case (cnt_ff[2:0])
               3'd0: issue_tag = P_LF;
               3'd1: issue_tag = P_RF;
               3'd2: issue_tag = P_LR;
               3'd3: issue_tag = P_RR;
               3'd4: issue_tag = P_NONE;    // wait for the turn sum
               3'd5: issue_tag = P_TURN_LO;
               3'd6: issue_tag = P_TURN_HI;
               3'd7: issue_tag = P_NONE;    // drain
            endcase
         end
         ST_MUL_ROT: begin
            unique case (cnt_ff)
               5'd0:    issue_tag = P_FC_LO;
               5'd1:    issue_tag = P_FC_HI;
               5'd2:    issue_tag = P_SS_LO;
               5'd3:    issue_tag = P_SS_HI;
               5'd4:    issue_tag = P_FS_LO;
               5'd5:    issue_tag = P_FS_HI;
               5'd6:    issue_tag = P_SC_LO;
               5'd7:    issue_tag = P_SC_HI;
               default: issue_tag = P_NONE;
            endcase
         end
         default: issue_tag = P_NONE;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      unique case (issue_tag)
         P_LF: begin
            mul_a = moi_pkg::MUL_A_W'(pulses_ff.pulses_front_left);
            mul_b = $signed({2'b00, coef_fl_ff});
         end
         P_RF: begin
            mul_a = moi_pkg::MUL_A_W'(pulses_ff.pulses_front_right);
            mul_b = $signed({2'b00, coef_fr_ff});
         end
         P_LR: begin
            mul_a = moi_pkg::MUL_A_W'(pulses_ff.pulses_rear_left);
            mul_b = $signed({2'b00, coef_rl_ff});
         end
         P_RR: begin
            mul_a = moi_pkg::MUL_A_W'(pulses_ff.pulses_rear_right);
            mul_b = $signed({2'b00, coef_rr_ff});
         end
         P_TURN_LO: begin
            mul_a = turn_sum_ff;
            mul_b = $signed({{(moi_pkg::MUL_B_W - moi_pkg::GAIN_HALF_W){1'b0}},
                             gain_ff[moi_pkg::GAIN_HALF_W-1:0]});
         end
         P_TURN_HI: begin
            mul_a = turn_sum_ff;
            mul_b = $signed({{(moi_pkg::MUL_B_W - moi_pkg::GAIN_HALF_W){1'b0}},
                             gain_ff[moi_pkg::GAIN_W-1:moi_pkg::GAIN_HALF_W]});
         end
         P_FC_LO: begin
            mul_a = moi_pkg::MUL_A_W'(fwd);
            mul_b = $signed({1'b0, cos_ff[moi_pkg::CS_LO_W-1:0]});
         end
         P_FC_HI: begin
            mul_a = moi_pkg::MUL_A_W'(fwd);
            mul_b = moi_pkg::MUL_B_W'($signed(cos_ff[moi_pkg::CS_W-1:moi_pkg::CS_LO_W]));
         end
         P_SS_LO: begin
            mul_a = moi_pkg::MUL_A_W'(side);
            mul_b = $signed({1'b0, sin_ff[moi_pkg::CS_LO_W-1:0]});
         end
         P_SS_HI: begin
            mul_a = moi_pkg::MUL_A_W'(side);
            mul_b = moi_pkg::MUL_B_W'($signed(sin_ff[moi_pkg::CS_W-1:moi_pkg::CS_LO_W]));
         end
         P_FS_LO: begin
            mul_a = moi_pkg::MUL_A_W'(fwd);
            mul_b = $signed({1'b0, sin_ff[moi_pkg::CS_LO_W-1:0]});
         end
         P_FS_HI: begin
            mul_a = moi_pkg::MUL_A_W'(fwd);
            mul_b = moi_pkg::MUL_B_W'($signed(sin_ff[moi_pkg::CS_W-1:moi_pkg::CS_LO_W]));
         end
         P_SC_LO: begin
            mul_a = moi_pkg::MUL_A_W'(side);
            mul_b = $signed({1'b0, cos_ff[moi_pkg::CS_LO_W-1:0]});
         end
         P_SC_HI: begin
            mul_a = moi_pkg::MUL_A_W'(side);
            mul_b = moi_pkg::MUL_B_W'($signed(cos_ff[moi_pkg::CS_W-1:moi_pkg::CS_LO_W]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // CORDIC shift and angle lookup
   assign x_sh     = x_ff >>> cnt_ff;
   assign y_sh     = y_ff >>> cnt_ff;
   assign atan_val = $signed(moi_pkg::ATAN_TABLE[cnt_ff]);

   // mid-step angle: heading plus half the turn
   assign mid       = heading_ff + turn_acc_ff[48:17];
   assign mid_shift = mid + moi_pkg::EIGHTH_TURN;

   // final pose
   assign new_x       = sat_add(world_x_ff, $signed(rot_x_ff[moi_pkg::ROT_W-1:30]));
   assign new_y       = sat_add(world_y_ff, $signed(rot_y_ff[moi_pkg::ROT_W-1:30]));
   assign new_heading = heading_ff + turn_acc_ff[47:16];

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tag_in       = issue_tag;
      prod_in      = mul_p;
      rsp_valid_in = rsp_valid_ff;
      coef_fl_in   = coef_fl_ff;
      coef_fr_in   = coef_fr_ff;
      coef_rl_in   = coef_rl_ff;
      coef_rr_in   = coef_rr_ff;
      gain_in      = gain_ff;
      world_x_in   = world_x_ff;
      world_y_in   = world_y_ff;
      heading_in   = heading_ff;
      pulses_in    = pulses_ff;
      rsp_data_in  = rsp_data_ff;
      fwd_sum_in   = fwd_sum_ff;
      side_sum_in  = side_sum_ff;
      turn_sum_in  = turn_sum_ff;
      turn_acc_in  = turn_acc_ff;
      rot_x_in     = rot_x_ff;
      rot_y_in     = rot_y_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      quad_in      = quad_ff;
      cos_in       = cos_ff;
      sin_in       = sin_ff;

      wheel_term = moi_pkg::SUM_W'(prod_ff);
      turn_term  = moi_pkg::TURN_W'(prod_ff);
      rot_term   = moi_pkg::ROT_W'(prod_ff);

      // register writes
      if (csr_write) begin
         unique case (csr_idx)
            moi_pkg::CSR_COEF_FL: coef_fl_in = csr_pwdata[15:0];
            moi_pkg::CSR_COEF_FR: coef_fr_in = csr_pwdata[15:0];
            moi_pkg::CSR_COEF_RL: coef_rl_in = csr_pwdata[15:0];
            moi_pkg::CSR_COEF_RR: coef_rr_in = csr_pwdata[15:0];
            moi_pkg::CSR_GAIN:    gain_in    = csr_pwdata[moi_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end

      // fold last cycle's product into its accumulator
      unique case (tag_ff)
         P_LF: begin
            fwd_sum_in  = fwd_sum_ff + wheel_term;
            side_sum_in = side_sum_ff - wheel_term;
            turn_sum_in = turn_sum_ff - wheel_term;
         end
         P_RF: begin
            fwd_sum_in  = fwd_sum_ff + wheel_term;
            side_sum_in = side_sum_ff + wheel_term;
            turn_sum_in = turn_sum_ff + wheel_term;
         end
         P_LR: begin
            fwd_sum_in  = fwd_sum_ff + wheel_term;
            side_sum_in = side_sum_ff + wheel_term;
            turn_sum_in = turn_sum_ff - wheel_term;
         end
         P_RR: begin
            fwd_sum_in  = fwd_sum_ff + wheel_term;
            side_sum_in = side_sum_ff - wheel_term;
            turn_sum_in = turn_sum_ff + wheel_term;
         end
         P_TURN_LO: turn_acc_in = turn_term;
         P_TURN_HI: turn_acc_in = turn_acc_ff + (turn_term <<< moi_pkg::GAIN_HALF_W);
         P_FC_LO:   rot_x_in = rot_x_ff + rot_term;
         P_FC_HI:   rot_x_in = rot_x_ff + (rot_term <<< moi_pkg::CS_LO_W);
         P_SS_LO:   rot_x_in = rot_x_ff - rot_term;
         P_SS_HI:   rot_x_in = rot_x_ff - (rot_term <<< moi_pkg::CS_LO_W);
         P_FS_LO:   rot_y_in = rot_y_ff + rot_term;
         P_FS_HI:   rot_y_in = rot_y_ff + (rot_term <<< moi_pkg::CS_LO_W);
         P_SC_LO:   rot_y_in = rot_y_ff + rot_term;
         P_SC_HI:   rot_y_in = rot_y_ff + (rot_term <<< moi_pkg::CS_LO_W);
         default: ;
      endcase

      // result beat taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pulses_in   = req_data;
               fwd_sum_in  = '0;
               side_sum_in = '0;
               turn_sum_in = '0;
               rot_x_in    = '0;
               rot_y_in    = '0;
               cnt_in      = '0;
               state_in    = ST_MUL_IN;
            end
         end
         ST_MUL_IN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd7) begin
               cnt_in   = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // quadrant fold: residual in [-1/8, 1/8) turn
            quad_in  = mid_shift[31:30];
            z_in     = $signed({2'b00, mid_shift[29:0]}) - $signed(moi_pkg::EIGHTH_TURN);
            x_in     = moi_pkg::CORDIC_GAIN;
            y_in     = '0;
            cnt_in   = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            if (!z_ff[31]) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_val;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == moi_pkg::CNT_W'(moi_pkg::CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_QUAD;
            end
         end
         ST_QUAD: begin
            // undo the quadrant fold
            unique case (quad_ff)
               2'd0: begin cos_in = x_ff;  sin_in = y_ff;  end
               2'd1: begin cos_in = -y_ff; sin_in = x_ff;  end
               2'd2: begin cos_in = -x_ff; sin_in = -y_ff; end
               2'd3: begin cos_in = y_ff;  sin_in = -x_ff; end
            endcase
            cnt_in   = '0;
            state_in = ST_MUL_ROT;
         end
         ST_MUL_ROT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd8) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               world_x_in          = new_x;
               world_y_in          = new_y;
               heading_in          = new_heading;
               rsp_data_in.pos_x   = 48'(new_x);
               rsp_data_in.pos_y   = 48'(new_y);
               rsp_data_in.heading = new_heading;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control, registers and pose
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         tag_ff       <= P_NONE;
         rsp_valid_ff <= 1'b0;
         coef_fl_ff   <= moi_pkg::COEF_FL_RESET;
         coef_fr_ff   <= moi_pkg::COEF_FR_RESET;
         coef_rl_ff   <= moi_pkg::COEF_RL_RESET;
         coef_rr_ff   <= moi_pkg::COEF_RR_RESET;
         gain_ff      <= moi_pkg::GAIN_RESET;
         world_x_ff   <= '0;
         world_y_ff   <= '0;
         heading_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_fl_ff   <= coef_fl_in;
         coef_fr_ff   <= coef_fr_in;
         coef_rl_ff   <= coef_rl_in;
         coef_rr_ff   <= coef_rr_in;
         gain_ff      <= gain_in;
         world_x_ff   <= world_x_in;
         world_y_ff   <= world_y_in;
         heading_ff   <= heading_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pulses_ff   <= pulses_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      fwd_sum_ff  <= fwd_sum_in;
      side_sum_ff <= side_sum_in;
      turn_sum_ff <= turn_sum_in;
      turn_acc_ff <= turn_acc_in;
      rot_x_ff    <= rot_x_in;
      rot_y_ff    <= rot_y_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      quad_ff     <= quad_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
   end

endmodule

`default_nettype wire

// ----- dv/odometry_checker.sv -----
// Pose predictor and result checker for the mecanum odometry integrator.
module odometry_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  moi_pkg::req_payload_type        req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  moi_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [moi_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   input  logic [31:0]                     csr_prdata,
   input  logic                            csr_pready,
   output int                              fail_count,
   output int                              beats_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import moi_pkg::*;

   // shadow copy of the register file
   logic [15:0]       coef_fl, coef_fr, coef_rl, coef_rr;
   logic [GAIN_W-1:0] turn_gain;

   // predicted pose
   longint      world_x, world_y;
   logic [31:0] heading_q;

   rsp_payload_type pose_q [$];
   int              error_total;

   // clamp a position sum to the signed accumulator range
   function automatic longint clamp_pos(input longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (POS_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // cos / sin in Q.30 of a binary angle: quadrant fold, then CORDIC on the residual
   function automatic void cordic_sincos(input logic [31:0] ang, output longint cs,
                                         output longint sn);
      logic [31:0] t;
      logic [1:0]  quad;
      longint      x, y, z, nx;
      t    = ang + EIGHTH_TURN;
      quad = t[31:30];
      z    = longint'(t[29:0]) - longint'(EIGHTH_TURN);
      x    = longint'(CORDIC_GAIN);
      y    = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ATAN_TABLE[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ATAN_TABLE[i]);
         end
         x = nx;
      end
      case (quad)
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endfunction

   // advance the pose by one set of pulse increments, return the new pose
   function automatic rsp_payload_type odo_advance(input req_payload_type p);
      longint          d_fl, d_fr, d_rl, d_rr;
      longint          fwd, side, dturn, cs, sn, dx, dy;
      logic [31:0]     mid;
      rsp_payload_type r;
      d_fl  = longint'($signed(p.pulses_front_left))  * longint'(coef_fl);
      d_fr  = longint'($signed(p.pulses_front_right)) * longint'(coef_fr);
      d_rl  = longint'($signed(p.pulses_rear_left))   * longint'(coef_rl);
      d_rr  = longint'($signed(p.pulses_rear_right))  * longint'(coef_rr);
      fwd   = (d_fl + d_fr + d_rl + d_rr) >>> 2;
      side  = (-d_fl + d_fr + d_rl - d_rr) >>> 2;
      dturn = ((-d_fl + d_fr - d_rl + d_rr) * longint'(turn_gain)) >>> 16;
      // rotate by the heading halfway through the turn
      mid = heading_q + 32'(dturn >>> 1);
      cordic_sincos(mid, cs, sn);
      dx = (fwd * cs - side * sn) >>> 30;
      dy = (fwd * sn + side * cs) >>> 30;
      world_x   = clamp_pos(world_x + dx);
      world_y   = clamp_pos(world_y + dy);
      heading_q = heading_q + 32'(dturn);
      r.pos_x   = world_x[47:0];
      r.pos_y   = world_y[47:0];
      r.heading = heading_q;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type        want, got;
      logic [CSR_IDX_W-1:0]   idx;
      logic [31:0]            reg_val;
      logic                   reg_known;
      idx = csr_paddr[CSR_ADDR_W-1:2];
      if (reset) begin
         coef_fl     = COEF_FL_RESET;
         coef_fr     = COEF_FR_RESET;
         coef_rl     = COEF_RL_RESET;
         coef_rr     = COEF_RR_RESET;
         turn_gain   = GAIN_RESET;
         world_x     = 0;
         world_y     = 0;
         heading_q   = '0;
         error_total = 0;
         pose_q.delete();
      end else begin
         // result beat against the oldest predicted pose
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (pose_q.size() == 0) begin
               $display("%0t: result beat with nothing pending, actual %h", $time, got);
               error_total++;
            end else begin
               want = pose_q.pop_front();
               if (got.pos_x !== want.pos_x) begin
                  $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
                  error_total++;
               end
               if (got.pos_y !== want.pos_y) begin
                  $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
                  error_total++;
               end
               if (got.heading !== want.heading) begin
                  $display("%0t: heading expected %h actual %h", $time, want.heading,
                           got.heading);
                  error_total++;
               end
            end
         end

         // register writes; unused indexes and upper bits are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (idx)
               CSR_COEF_FL: coef_fl   = csr_pwdata[15:0];
               CSR_COEF_FR: coef_fr   = csr_pwdata[15:0];
               CSR_COEF_RL: coef_rl   = csr_pwdata[15:0];
               CSR_COEF_RR: coef_rr   = csr_pwdata[15:0];
               CSR_GAIN:    turn_gain = csr_pwdata[GAIN_W-1:0];
               default: ;
            endcase
         end

         // register reads
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            reg_known = 1'b1;
            case (idx)
               CSR_COEF_FL: reg_val = 32'(coef_fl);
               CSR_COEF_FR: reg_val = 32'(coef_fr);
               CSR_COEF_RL: reg_val = 32'(coef_rl);
               CSR_COEF_RR: reg_val = 32'(coef_rr);
               CSR_GAIN:    reg_val = 32'(turn_gain);
               default: begin
                  reg_val   = '0;
                  reg_known = 1'b0;
               end
            endcase
            if (reg_known && csr_prdata !== reg_val) begin
               $display("%0t: register %0d expected %h actual %h", $time, idx, reg_val,
                        csr_prdata);
               error_total++;
            end
         end

         // accepted request beat
         if (req_valid && req_ready)
            pose_q.push_back(odo_advance(req_data));
      end
      fail_count    <= error_total;
      beats_pending <= pose_q.size();
   end

endmodule

// ----- dv/tb.sv -----
// Stimulus, clocking and verdict for the mecanum odometry integrator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import moi_pkg::*;

   localparam logic signed [15:0] PULSE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] PULSE_MIN = 16'sh8000;
   localparam int ITEMS_PER_PHASE = 275;
   localparam int HOLD_AT_BEAT    = 200;
   localparam int HOLD_CYCLES     = 400;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_payload_type        req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_payload_type        rsp_data;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [31:0]            csr_pwdata;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   int fail_count;
   int beats_pending;
   int send_burst;

   mecanum_odometry_integrator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   odometry_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .beats_pending (beats_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle cycles before the next beat; occasional runs of back-to-back beats
   function automatic int draw_wait(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic req_payload_type wheels(input logic signed [15:0] fl,
                                              input logic signed [15:0] fr,
                                              input logic signed [15:0] rl,
                                              input logic signed [15:0] rr);
      req_payload_type p;
      p.pulses_front_left  = fl;
      p.pulses_front_right = fr;
      p.pulses_rear_left   = rl;
      p.pulses_rear_right  = rr;
      return p;
   endfunction

   function automatic logic signed [15:0] edge_pulse();
      case ($urandom_range(0, 4))
         0: return PULSE_MIN;
         1: return -16'sd1;
         2: return 16'sd0;
         3: return 16'sd1;
         default: return PULSE_MAX;
      endcase
   endfunction

   // random pulse set: full range, slow creep, straight runs, spins, strafes, extremes
   function automatic req_payload_type random_pulses();
      logic signed [15:0] v;
      v = 16'($urandom());
      case ($urandom_range(0, 9))
         0, 1, 2, 3:
            return wheels(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
         4, 5:
            return wheels(16'(int'($urandom_range(0, 127)) - 64),
                          16'(int'($urandom_range(0, 127)) - 64),
                          16'(int'($urandom_range(0, 127)) - 64),
                          16'(int'($urandom_range(0, 127)) - 64));
         6: return wheels(v, v, v, v);
         7: return wheels(-v, v, -v, v);
         8: return wheels(-v, v, v, -v);
         default: return wheels(edge_pulse(), edge_pulse(), edge_pulse(), edge_pulse());
      endcase
   endfunction

   // one request beat, held until the block takes it
   task automatic offer_pulses(input req_payload_type p);
      int gap;
      gap = draw_wait(send_burst);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every predicted pose has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (beats_pending == 0);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_IDX_W-1:0] idx,
                             input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, one long hold-off to back up the block
   initial begin : rsp_sink
      int stall, burst, taken;
      burst     = 0;
      taken     = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = (taken == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_wait(burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [31:0] cfg [5];
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      send_burst  = 0;
      reset       = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset values of the registers, then directed beats at default coefficients
      for (int k = CSR_COEF_FL; k <= CSR_GAIN; k++)
         csr_access(1'b0, CSR_IDX_W'(k), '0);
      offer_pulses(wheels(16'sd0, 16'sd0, 16'sd0, 16'sd0));
      offer_pulses(wheels(PULSE_MAX, PULSE_MAX, PULSE_MAX, PULSE_MAX));
      offer_pulses(wheels(PULSE_MIN, PULSE_MIN, PULSE_MIN, PULSE_MIN));
      offer_pulses(wheels(PULSE_MIN, PULSE_MAX, PULSE_MIN, PULSE_MAX));
      offer_pulses(wheels(PULSE_MAX, PULSE_MIN, PULSE_MAX, PULSE_MIN));
      offer_pulses(wheels(PULSE_MIN, PULSE_MAX, PULSE_MAX, PULSE_MIN));
      offer_pulses(wheels(PULSE_MAX, PULSE_MIN, PULSE_MIN, PULSE_MAX));
      offer_pulses(wheels(PULSE_MAX, 16'sd0, 16'sd0, 16'sd0));
      offer_pulses(wheels(16'sd0, PULSE_MAX, 16'sd0, 16'sd0));
      offer_pulses(wheels(16'sd0, 16'sd0, PULSE_MAX, 16'sd0));
      offer_pulses(wheels(16'sd0, 16'sd0, 16'sd0, PULSE_MAX));
      offer_pulses(wheels(-16'sd1, -16'sd1, -16'sd1, -16'sd1));
      offer_pulses(wheels(16'sd1, 16'sd1, 16'sd1, 16'sd1));
      drain();

      // full-scale registers written with upper bits set; unused indexes ignored
      for (int k = CSR_COEF_FL; k <= CSR_GAIN; k++)
         csr_access(1'b1, CSR_IDX_W'(k), 32'hFFFF_FFFF);
      for (int k = CSR_GAIN + 1; k < (1 << CSR_IDX_W); k++)
         csr_access(1'b1, CSR_IDX_W'(k), $urandom());
      for (int k = CSR_COEF_FL; k <= CSR_GAIN; k++)
         csr_access(1'b0, CSR_IDX_W'(k), '0);
      offer_pulses(wheels(PULSE_MAX, PULSE_MAX, PULSE_MAX, PULSE_MAX));
      offer_pulses(wheels(PULSE_MIN, PULSE_MAX, PULSE_MIN, PULSE_MAX));
      offer_pulses(wheels(PULSE_MIN, PULSE_MIN, PULSE_MIN, PULSE_MIN));
      offer_pulses(wheels(PULSE_MAX, PULSE_MIN, PULSE_MAX, PULSE_MIN));
      offer_pulses(wheels(PULSE_MIN, PULSE_MAX, PULSE_MAX, PULSE_MIN));
      drain();

      // all-zero registers: the pose must hold
      for (int k = CSR_COEF_FL; k <= CSR_GAIN; k++)
         csr_access(1'b1, CSR_IDX_W'(k), '0);
      offer_pulses(wheels(PULSE_MAX, PULSE_MAX, PULSE_MAX, PULSE_MAX));
      offer_pulses(wheels(PULSE_MIN, PULSE_MAX, PULSE_MIN, PULSE_MAX));
      drain();

      // random phases, each with its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         for (int k = 0; k < 4; k++) begin
            case (ph)
               0:       cfg[k] = $urandom_range(2400, 2900);
               1:       cfg[k] = $urandom();
               2:       cfg[k] = 32'h0000_FFFF;
               default: cfg[k] = $urandom_range(0, 65535);
            endcase
         end
         case (ph)
            0:       cfg[CSR_GAIN] = $urandom_range(5000000, 6000000);
            1:       cfg[CSR_GAIN] = $urandom();
            2:       cfg[CSR_GAIN] = 32'h00FF_FFFF;
            3:       cfg[CSR_GAIN] = $urandom_range(0, 255);
            4:       cfg[CSR_GAIN] = '0;
            default: cfg[CSR_GAIN] = $urandom_range(0, 24'hFF_FFFF);
         endcase
         for (int k = CSR_COEF_FL; k <= CSR_GAIN; k++)
            csr_access(1'b1, CSR_IDX_W'(k), cfg[k]);
         for (int k = CSR_COEF_FL; k <= CSR_GAIN; k++)
            csr_access(1'b0, CSR_IDX_W'(k), '0);
         repeat (ITEMS_PER_PHASE) offer_pulses(random_pulses());
         drain();
      end

      // let any stray result show up before the verdict
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
